@@ hw/rtl/bihr_pkg.sv @@
// shared types, command/status structs and constants for the beat interval heart rate block
package bihr_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_OFFSET = 1'b1;

  // field widths
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned OFFSET_W = 6;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 8;

  localparam logic [LIMIT_W-1:0]  CALIB_LIMIT_RST = 16'd1000;
  localparam logic [OFFSET_W-1:0] RATE_OFFSET_RST = 6'd6;

  // arithmetic constants
  localparam logic [15:0]         MS_PER_MIN = 16'd60000;
  localparam logic [RATE_W-1:0]   RATE_MAX   = 8'd255;
  localparam logic [OFFSET_W-1:0] RATE_MIN   = 6'd60;
  localparam logic [3:0]          RATIO_HI   = 4'd13;
  localparam logic [3:0]          RATIO_LO   = 4'd10;

  // divider widths: dividends never exceed 20 bits, divisors may take the full interval
  localparam int unsigned DVD_W = 20;
  localparam int unsigned DVS_W = 32;

  // request operation codes
  localparam logic OP_BEAT    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // divider divisor selection
  typedef logic div_sel_t;
  localparam div_sel_t DIV_RATE_REF   = 1'b0;
  localparam div_sel_t DIV_RATE_DELTA = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] beat_time_ms;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0] bpm;
    logic              calibrated;
    logic              beat_accepted;
  } out_t;

  typedef struct packed {
    logic     capture;
    logic     eval;
    logic     div_start;
    div_sel_t div_sel;
    logic     ref_load;
    logic     rate_load;
    logic     rate_max;
    logic     push;
    logic     cur_from_rate;
    logic     cur_from_avg;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic calib_done;
    logic calib_ok;
    logic calib_last;
    logic post_ok;
    logic ref_zero;
    logic ring_full;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/bihr_div.sv @@
// restoring divider, one quotient bit per cycle
module bihr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bihr_pkg::DVD_W-1:0] dividend,
  input  logic [bihr_pkg::DVS_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [bihr_pkg::DVD_W-1:0] quotient
);
  import bihr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W:0]   rem_sh;
  logic [DVS_W:0]   diff;

  always_comb begin
    rem_sh = {rem_r, quo_r[DVD_W-1]};
    diff   = {{(DVS_W-DVD_W){1'b0}}, rem_sh} - {1'b0, dvs_r};
    if (!diff[DVS_W]) begin
      rem_nxt = diff[DVD_W-1:0];
    end else begin
      rem_nxt = rem_sh[DVD_W-1:0];
    end
    quo_nxt = {quo_r[DVD_W-2:0], ~diff[DVS_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(DVD_W + 1) done_r)
    else $error("divider did not finish in the expected number of cycles");

endmodule

@@ hw/rtl/bihr_dp.sv @@
// datapath: config registers, calibration, acceptance checks, rate ring and result register
module bihr_dp #(
  parameter int unsigned CALIB_DEPTH = 4,
  parameter int unsigned RATE_DEPTH  = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bihr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bihr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  bihr_pkg::in_t                  in_data,
  input  bihr_pkg::cmd_t                 cmd,
  output bihr_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bihr_pkg::out_t                 out_data
);
  import bihr_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CALIB_DEPTH + 1);
  localparam int unsigned SUM_W  = LIMIT_W + CNT_W;
  localparam int unsigned FILL_W = $clog2(RATE_DEPTH + 1);
  localparam int unsigned HEAD_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int unsigned RSUM_W = RATE_W + FILL_W;

  // constant divides as reciprocal multiplies, exact for every operand below 2^width
  localparam int unsigned MEAN_SH = SUM_W + $clog2(CALIB_DEPTH);
  localparam int unsigned MEAN_MW = MEAN_SH + 1;
  localparam logic [MEAN_MW-1:0] MEAN_MUL =
    MEAN_MW'(((64'd1 << MEAN_SH) + 64'(CALIB_DEPTH) - 64'd1) / 64'(CALIB_DEPTH));
  localparam int unsigned AVG_SH  = RSUM_W + $clog2(RATE_DEPTH);
  localparam int unsigned AVG_MW  = AVG_SH + 1;
  localparam logic [AVG_MW-1:0] AVG_MUL =
    AVG_MW'(((64'd1 << AVG_SH) + 64'(RATE_DEPTH) - 64'd1) / 64'(RATE_DEPTH));

  // config
  logic [LIMIT_W-1:0]  limit_r;
  logic [OFFSET_W-1:0] offset_r;

  // architectural state
  logic [TIME_W-1:0] last_r;
  logic              calib_done_r;
  logic [SUM_W-1:0]  calib_sum_r;
  logic [CNT_W-1:0]  calib_count_r;
  logic [TIME_W-1:0] ref_r;
  logic [RATE_W-1:0] ring_r [RATE_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [HEAD_W-1:0] head_r;
  logic [RSUM_W-1:0] rsum_r;
  logic [RATE_W-1:0] cur_r;

  // per request working registers
  logic              op_r;
  logic [TIME_W-1:0] delta_r;
  logic [RATE_W-1:0] rate_r;
  logic              acc_r;
  logic              out_valid_r;
  out_t              out_data_r;

  // combinational
  logic [TIME_W-1:0]  delta_in;
  logic               calib_ok;
  logic [CNT_W-1:0]   count_inc;
  logic               calib_last;
  logic [SUM_W-1:0]   sum_inc;
  logic [SUM_W+MEAN_MW-1:0] mean_prod;
  logic [SUM_W-1:0]   calib_mean;
  logic [RSUM_W+AVG_MW-1:0] avg_prod;
  logic [RSUM_W-1:0]  ring_avg;
  logic [OFFSET_W-1:0] lo_coef;
  logic [RATE_W-1:0]  hi_coef;
  logic [37:0]        lo_prod;
  logic [39:0]        hi_prod;
  logic               above, below;
  logic [35:0]        d10, d13, r10, r13;
  logic               ratio_ok;
  logic               post_ok;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_busy, div_done;
  logic [DVD_W-1:0]   div_quo;
  logic [DVD_W:0]     rate_sum;
  logic [RATE_W-1:0]  rate_sat;
  logic               ring_full;
  logic [RSUM_W-1:0]  rsum_drop;
  logic [HEAD_W-1:0]  head_inc;
  logic               out_free;

  assign delta_in   = in_data.beat_time_ms - last_r;
  assign calib_ok   = delta_r < {{(TIME_W-LIMIT_W){1'b0}}, limit_r};
  assign count_inc  = calib_count_r + 1'b1;
  assign calib_last = count_inc == CNT_W'(CALIB_DEPTH);
  // only used when the interval is below the 16-bit limit
  assign sum_inc    = calib_sum_r + SUM_W'(delta_r[LIMIT_W-1:0]);

  assign mean_prod  = (SUM_W+MEAN_MW)'(calib_sum_r) * (SUM_W+MEAN_MW)'(MEAN_MUL);
  assign calib_mean = SUM_W'(mean_prod >> MEAN_SH);
  assign avg_prod   = (RSUM_W+AVG_MW)'(rsum_r) * (RSUM_W+AVG_MW)'(AVG_MUL);
  assign ring_avg   = RSUM_W'(avg_prod >> AVG_SH);

  // rate = 60000/d + off strictly between 60 and 255, rewritten without a divide
  assign lo_coef  = RATE_MIN - offset_r;
  assign hi_coef  = RATE_MAX - RATE_W'(offset_r);
  assign lo_prod  = {32'b0, lo_coef} * {6'b0, delta_r};
  assign hi_prod  = {32'b0, hi_coef} * {8'b0, delta_r};
  assign above    = (offset_r >= RATE_MIN) || (lo_prod < 38'(MS_PER_MIN));
  assign below    = hi_prod > 40'(MS_PER_MIN);

  // reference window 10/13 .. 13/10
  assign d10      = 36'(delta_r) * 36'(RATIO_LO);
  assign d13      = 36'(delta_r) * 36'(RATIO_HI);
  assign r10      = 36'(ref_r) * 36'(RATIO_LO);
  assign r13      = 36'(ref_r) * 36'(RATIO_HI);
  assign ratio_ok = !(d10 > r13) && !(d13 < r10);
  assign post_ok  = above && below && ratio_ok && (delta_r != '0);

  assign div_dvd = DVD_W'(MS_PER_MIN);
  assign div_dvs = (cmd.div_sel == DIV_RATE_REF) ? ref_r : delta_r;

  bihr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign rate_sum  = {1'b0, div_quo} + (DVD_W+1)'(offset_r);
  assign rate_sat  = (rate_sum > (DVD_W+1)'(RATE_MAX)) ? RATE_MAX : rate_sum[RATE_W-1:0];
  assign ring_full = fill_r == FILL_W'(RATE_DEPTH);
  // oldest entry leaves the sum once the ring has wrapped
  assign rsum_drop = ring_full ? RSUM_W'(ring_r[head_r]) : '0;
  assign head_inc  = (head_r == HEAD_W'(RATE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= CALIB_LIMIT_RST;
      offset_r      <= RATE_OFFSET_RST;
      last_r        <= '0;
      calib_done_r  <= 1'b0;
      calib_sum_r   <= '0;
      calib_count_r <= '0;
      ref_r         <= '0;
      fill_r        <= '0;
      head_r        <= '0;
      rsum_r        <= '0;
      cur_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx)
          CFG_CALIB_LIMIT: limit_r  <= cfg_wdata;
          CFG_RATE_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
        endcase
      end
      if (cmd.capture && in_data.operation == OP_BEAT) begin
        last_r <= in_data.beat_time_ms;
      end
      if (cmd.eval) begin
        if (op_r == OP_RESTART) begin
          calib_done_r  <= 1'b0;
          calib_sum_r   <= '0;
          calib_count_r <= '0;
        end else if (!calib_done_r) begin
          if (calib_ok) begin
            if (calib_last) begin
              // full sum registered first so the mean is taken from a register
              calib_done_r  <= 1'b1;
              calib_sum_r   <= sum_inc;
              calib_count_r <= '0;
            end else begin
              calib_sum_r   <= sum_inc;
              calib_count_r <= count_inc;
            end
          end
        end else if (post_ok) begin
          ref_r <= delta_r;
        end
      end
      if (cmd.ref_load) begin
        ref_r       <= TIME_W'(calib_mean);
        calib_sum_r <= '0;
      end
      if (cmd.push) begin
        head_r <= head_inc;
        rsum_r <= rsum_r - rsum_drop + RSUM_W'(rate_r);
        if (!ring_full) begin
          fill_r <= fill_r + 1'b1;
        end
        if (cmd.cur_from_rate) begin
          cur_r <= rate_r;
        end
      end
      if (cmd.cur_from_avg) begin
        cur_r <= ring_avg[RATE_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.operation;
      delta_r <= delta_in;
    end
    if (cmd.eval) begin
      if (op_r == OP_RESTART) begin
        acc_r <= 1'b0;
      end else if (!calib_done_r) begin
        acc_r <= calib_ok;
      end else begin
        acc_r <= post_ok;
      end
    end
    if (cmd.rate_max) begin
      rate_r <= RATE_MAX;
    end else if (cmd.rate_load) begin
      rate_r <= rate_sat;
    end
    if (cmd.push) begin
      ring_r[head_r] <= rate_r;
    end
    if (cmd.out_load) begin
      out_data_r.bpm           <= cur_r;
      out_data_r.calibrated    <= calib_done_r;
      out_data_r.beat_accepted <= acc_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.restart    = op_r == OP_RESTART;
    sts.calib_done = calib_done_r;
    sts.calib_ok   = calib_ok;
    sts.calib_last = calib_last;
    sts.post_ok    = post_ok;
    sts.ref_zero   = ref_r == '0;
    sts.ring_full  = ring_full;
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_calib_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    calib_done_r |-> calib_count_r == '0)
    else $error("calibration count left nonzero after calibration");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(RATE_DEPTH))
    else $error("rate ring fill beyond depth");

endmodule

@@ hw/rtl/bihr_ctrl.sv @@
// controller: sequences capture, checks, divisions, ring update and result hand-off
module bihr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bihr_pkg::sts_t sts,
  output bihr_pkg::cmd_t cmd
);
  import bihr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EVAL     = 4'd1;
  localparam logic [3:0] S_MEAN     = 4'd2;
  localparam logic [3:0] S_MEAN_CHK = 4'd3;
  localparam logic [3:0] S_DIV_RATE = 4'd4;
  localparam logic [3:0] S_PUSH     = 4'd5;
  localparam logic [3:0] S_AVG_CHK  = 4'd6;
  localparam logic [3:0] S_FINISH   = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       cal_path_r, cal_path_nxt;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cal_path_nxt = cal_path_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.restart) begin
          state_nxt = S_FINISH;
        end else if (!sts.calib_done) begin
          if (sts.calib_ok && sts.calib_last) begin
            cal_path_nxt = 1'b1;
            state_nxt    = S_MEAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (sts.post_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATE_DELTA;
          cal_path_nxt  = 1'b0;
          state_nxt     = S_DIV_RATE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_MEAN: begin
        cmd.ref_load = 1'b1;
        state_nxt    = S_MEAN_CHK;
      end
      S_MEAN_CHK: begin
        // zero mean saturates the first rate
        if (sts.ref_zero) begin
          cmd.rate_max = 1'b1;
          state_nxt    = S_PUSH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATE_REF;
          state_nxt     = S_DIV_RATE;
        end
      end
      S_DIV_RATE: begin
        if (sts.div_done) begin
          cmd.rate_load = 1'b1;
          state_nxt     = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push          = 1'b1;
        cmd.cur_from_rate = cal_path_r;
        state_nxt         = cal_path_r ? S_FINISH : S_AVG_CHK;
      end
      S_AVG_CHK: begin
        cmd.cur_from_avg = sts.ring_full;
        state_nxt        = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cal_path_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cal_path_r <= cal_path_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("division started while divider busy");

  a_out_free_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

endmodule

@@ hw/rtl/beat_interval_heart_rate.sv @@
// top level: heart rate from beat intervals with calibration and a ring average
//
// in_valid/in_ready carry one request: a beat with its millisecond timestamp, or a
// restart of calibration. out_valid/out_ready carry one result per request: the
// current heart rate, the calibrated flag and whether the beat was kept.
// cfg_wr_en writes cfg_wdata into register cfg_idx (0 calibration limit,
// 1 rate offset); write only while no request is in flight.
// One request is worked on at a time. A restart or a beat that is not kept has
// its result loaded straight after evaluation; a kept beat after calibration
// goes through one pass of the 20-step restoring divider for 60000 / interval,
// the ring push and the ring average check, and a beat that ends calibration
// loads the mean as reference and divides 60000 by it (no divide when the mean
// is zero). The calibration and ring means are constant reciprocal multiplies.
// in_ready returns in the cycle after the result is loaded.
// A result waiting on out_ready does not stop the next request; the next result
// waits in place until the first is taken, with in_ready low meanwhile.
// Synchronous reset returns to the idle state with all history cleared and the
// configuration at its defaults; the rate ring needs no clearing.
module beat_interval_heart_rate #(
  parameter int unsigned CALIB_DEPTH = 4,
  parameter int unsigned RATE_DEPTH  = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bihr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bihr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bihr_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bihr_pkg::out_t                 out_data
);
  import bihr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bihr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bihr_dp #(
    .CALIB_DEPTH (CALIB_DEPTH),
    .RATE_DEPTH  (RATE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/beat_interval_heart_rate_test.sv @@
// testbench for the beat interval heart rate block: directed and random requests against a predictor
module beat_interval_heart_rate_test;
  import bihr_pkg::*;

  localparam int CALIB_BEATS     = 4;
  localparam int RING_DEPTH      = 4;
  localparam int SETTLE_CYCLES   = 64;
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_REQUESTS = 950;
  localparam int STEADY_REQUESTS = 150;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;

  // predicted block state, at reset values
  logic [LIMIT_W-1:0]  limit_reg    = CALIB_LIMIT_RST;
  logic [OFFSET_W-1:0] offset_reg   = RATE_OFFSET_RST;
  logic [TIME_W-1:0]   last_beat    = '0;
  logic                calib_flag   = 1'b0;
  logic [31:0]         calib_acc    = '0;
  int                  calib_n      = 0;
  logic [31:0]         ref_interval = '0;
  logic [RATE_W-1:0]   ring [RING_DEPTH];
  int                  ring_fill    = 0;
  int                  ring_head    = 0;
  int                  ring_total   = 0;
  logic [RATE_W-1:0]   cur_rate     = '0;

  out_t              expected_readings [$];
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;
  int                stall_pct      = 23;
  logic [TIME_W-1:0] beat_clock     = '0;

  beat_interval_heart_rate #(
    .CALIB_DEPTH (CALIB_BEATS),
    .RATE_DEPTH  (RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void push_rate(logic [RATE_W-1:0] rate);
    if (ring_fill >= RING_DEPTH) ring_total -= ring[ring_head];
    else ring_fill++;
    ring[ring_head] = rate;
    ring_total += rate;
    ring_head = (ring_head + 1) % RING_DEPTH;
  endfunction

  function automatic out_t predict_reading(in_t req);
    logic [TIME_W-1:0] delta;
    logic [31:0]       mean;
    longint unsigned   d, refv, num, rate;
    logic              kept;
    out_t              res;
    kept = 1'b0;
    if (req.operation == OP_RESTART) begin
      calib_flag = 1'b0;
      calib_acc  = '0;
      calib_n    = 0;
    end else begin
      delta = req.beat_time_ms - last_beat;
      last_beat = req.beat_time_ms;
      if (!calib_flag) begin
        if (delta < {16'd0, limit_reg}) begin
          kept = 1'b1;
          calib_acc += delta;
          calib_n++;
          if (calib_n >= CALIB_BEATS) begin
            mean = calib_acc / CALIB_BEATS;
            ref_interval = mean;
            calib_acc = '0;
            calib_n = 0;
            calib_flag = 1'b1;
            if (mean == 0) rate = RATE_MAX;
            else rate = 64'(MS_PER_MIN) / mean + offset_reg;
            if (rate > RATE_MAX) rate = RATE_MAX;
            cur_rate = rate[RATE_W-1:0];
            push_rate(rate[RATE_W-1:0]);
          end
        end
      end else begin
        d    = delta;
        refv = ref_interval;
        num  = 64'(MS_PER_MIN) + offset_reg * d;
        // rate strictly inside (60, 255) and interval within 10/13..13/10 of the reference
        if (num > RATE_MIN * d && num < RATE_MAX * d && !(10 * d > 13 * refv) &&
            !(13 * d < 10 * refv) && delta != 0) begin
          rate = 64'(MS_PER_MIN) / d + offset_reg;
          if (rate > RATE_MAX) rate = RATE_MAX;
          kept = 1'b1;
          ref_interval = delta;
          push_rate(rate[RATE_W-1:0]);
          if (ring_fill >= RING_DEPTH) cur_rate = 8'(ring_total / ring_fill);
        end
      end
    end
    res.bpm           = cur_rate;
    res.calibrated    = calib_flag;
    res.beat_accepted = kept;
    return res;
  endfunction

  // valid stays high between back-to-back requests; it is lowered only on a gap
  task automatic send_request(in_t req);
    logic taken;
    if ($urandom_range(99) < stall_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < stall_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready;
      if (taken) expected_readings = {expected_readings, predict_reading(req)};
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_beat(logic [TIME_W-1:0] stamp);
    in_t req;
    req.operation    = OP_BEAT;
    req.beat_time_ms = stamp;
    beat_clock = stamp;
    send_request(req);
  endtask

  task automatic send_restart();
    in_t req;
    req.operation    = OP_RESTART;
    req.beat_time_ms = $urandom;
    send_request(req);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [LIMIT_W-1:0] limit, logic [OFFSET_W-1:0] offset);
    logic [CFG_DATA_W-OFFSET_W-1:0] pad;
    pad = (CFG_DATA_W-OFFSET_W)'($urandom);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= CFG_CALIB_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    limit_reg = limit;
    cfg_idx   <= CFG_RATE_OFFSET;
    cfg_wdata <= {pad, offset};
    @(posedge clk);
    offset_reg = offset;
    cfg_wr_en <= 1'b0;
  endtask

  // sessions of an optional config write and restart, calibration and a drifting beat train, with noise mixed in
  task automatic run_sessions(int count);
    int                  sent, base, beats, interval_ms;
    logic [LIMIT_W-1:0]  limit;
    logic [OFFSET_W-1:0] offset;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0:       limit = 16'hFFFF;
          1:       limit = 16'd1;
          2:       limit = LIMIT_W'($urandom_range(200, 1200));
          3:       limit = LIMIT_W'($urandom);
          default: limit = LIMIT_W'($urandom_range(1500, 4000));
        endcase
        case ($urandom_range(3))
          0:       offset = '0;
          1:       offset = '1;
          default: offset = OFFSET_W'($urandom);
        endcase
        settle_block();
        write_config(limit, offset);
      end
      if ($urandom_range(4) != 0) begin
        send_restart();
        sent++;
      end
      base = $urandom_range(240, 1400);
      for (int i = 0; i < CALIB_BEATS; i++) begin
        send_beat(beat_clock + base + $urandom_range(0, base / 10) - base / 20);
        sent++;
      end
      beats = $urandom_range(6, 30);
      interval_ms = base;
      for (int i = 0; i < beats; i++) begin
        case ($urandom_range(19))
          0: send_restart();
          1: send_beat($urandom);
          2: send_beat(beat_clock);
          3: send_beat(beat_clock - $urandom_range(1, 5000));
          4: send_beat(beat_clock + $urandom_range(0, 5000));
          default: begin
            interval_ms = interval_ms * $urandom_range(85, 115) / 100;
            if (interval_ms < 200) interval_ms = 200;
            if (interval_ms > 1500) interval_ms = 1500;
            send_beat(beat_clock + interval_ms);
          end
        endcase
        sent++;
      end
    end
  endtask

  // identical timestamps give a zero mean, then the zero reference blocks every beat
  task automatic test_zero_calibration_mean();
    repeat (CALIB_BEATS) send_beat(32'd0);
    send_beat(32'd0);
    send_beat(32'd800);
  endtask

  task automatic test_ring_and_ratio_limits();
    send_restart();
    send_beat(32'd1600);
    send_beat(32'd2400);
    send_beat(32'd3200);
    send_beat(32'd4000);
    send_beat(32'd4820);
    send_beat(32'd5600);
    send_beat(32'd6400);
    send_beat(32'd8400);
    // exactly 1.3x above, then exactly 1/1.3 below the reference
    send_beat(32'd9440);
    send_beat(32'd10240);
    // recalibration with the ring already full
    send_restart();
    send_beat(32'd10840);
    send_beat(32'd11440);
    send_beat(32'd12040);
    send_beat(32'd12640);
    // timestamp going backwards, then the top of the range
    send_beat(32'd12000);
    send_beat(32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes();
    settle_block();
    write_config(16'd0, 6'd0);
    send_restart();
    send_beat(beat_clock + 500);
    send_beat(beat_clock);
    settle_block();
    write_config(16'hFFFF, 6'd63);
    send_restart();
    send_beat(beat_clock + 65534);
    repeat (CALIB_BEATS - 1) send_beat(beat_clock);
    send_beat(beat_clock + 16000);
  endtask

  task automatic test_random_sessions();
    settle_block();
    write_config(CALIB_LIMIT_RST, RATE_OFFSET_RST);
    run_sessions(RANDOM_REQUESTS);
  endtask

  task automatic test_steady_stream();
    stall_pct = 0;
    run_sessions(STEADY_REQUESTS);
    settle_block();
    stall_pct = 23;
  endtask

  always @(negedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("result with no request pending: bpm %0d", out_data.bpm);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_data.bpm !== want.bpm) begin
          $error("bpm expected %0d actual %0d", want.bpm, out_data.bpm);
          mismatch_count++;
        end
        if (out_data.calibrated !== want.calibrated) begin
          $error("calibrated expected %0d actual %0d", want.calibrated, out_data.calibrated);
          mismatch_count++;
        end
        if (out_data.beat_accepted !== want.beat_accepted) begin
          $error("beat_accepted expected %0d actual %0d", want.beat_accepted,
                 out_data.beat_accepted);
          mismatch_count++;
        end
      end
    end
  end

  // no request moving on either side for too long means the block is stuck
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_calibration_mean();
    test_ring_and_ratio_limits();
    test_register_extremes();
    test_random_sessions();
    test_steady_stream();
    settle_block();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
